// ===== rtl/dnsle_pkg.sv =====
// Shared types and constants for the DNS name label encoder.
// No dependencies; every other file of the block imports this package.
package dnsle_pkg;

  localparam int unsigned MAX_LABEL   = 62;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RAM_AW      = CNT_W + 1;
  localparam int unsigned RAM_DEPTH   = 2 ** RAM_AW;
  localparam int unsigned OFIFO_AW    = 2;
  localparam int unsigned OFIFO_DEPTH = 2 ** OFIFO_AW;

  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

  // One label flush handed from the front to the back.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             term;
  } cmd_t;

  // Back end hands a label bank back to the front.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
    logic              tl;
  } res_t;

endpackage

// ===== rtl/dns_name_label_encoder.sv =====
// Top level of the DNS name label encoder: front end, command queue, label
// store and back end. Depends on dnsle_pkg and the dnsle_* submodules.
// Usage:
//   Input queue: drive char_in_i and end_of_name_i with push; a beat is
//   taken at a rising edge with push high and full low. One beat carries
//   one hostname character; end_of_name_i marks the last one.
//   Result queue: while empty is low the oldest encoded byte sits on
//   byte_out_o with its flags; pop high takes it at the rising edge.
//   A dot or the last character flushes the open label as a length byte and
//   its characters; the last character also adds a zero terminator.
// Timing:
//   Plain characters go in at one per cycle while full is low. The label store
//   has two banks, so the front fills the next label while the back plays out
//   the previous one; full rises only when the front returns to a bank the
//   back still reads. A flush passes the command queue, the back end's state
//   register and the read stage into a 4-deep result queue; its bytes follow
//   at one per cycle, read through the single store read port, while the result queue has room.
// Reset: clears the counters, bank ownership and both queues; store contents
//   are not cleared. A stalled result side fills the result queue and halts
//   the back end; the front keeps accepting until it returns to a busy bank.
module dns_name_label_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       end_of_name_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out_o,
  output logic       last_of_run_o,
  output logic       name_done_o,
  output logic       too_long_o
);
  import dnsle_pkg::*;

  cmd_t              f_cmd, b_cmd;
  logic              f_cmd_push, cmd_full, cmd_empty, cmd_pop;
  ram_wr_t           ram_wr;
  logic [RAM_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  release_t          rel;

  dnsle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .char_in_i     (char_in_i),
    .end_of_name_i (end_of_name_i),
    .full_o        (full),
    .rel_i         (rel),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (f_cmd_push),
    .cmd_o         (f_cmd),
    .wr_o          (ram_wr)
  );

  dnsle_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_cmd_push),
    .data_i  (f_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (b_cmd),
    .empty_o (cmd_empty)
  );

  dnsle_label_ram u_label_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dnsle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (b_cmd),
    .cmd_pop_o     (cmd_pop),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .rel_o         (rel),
    .empty_o       (empty),
    .pop_i         (pop),
    .byte_out_o    (byte_out_o),
    .last_of_run_o (last_of_run_o),
    .name_done_o   (name_done_o),
    .too_long_o    (too_long_o)
  );

endmodule

// ===== rtl/dnsle_label_ram.sv =====
// Two-bank label character store: one write port, one registered read port.
// Depends on dnsle_pkg.
module dnsle_label_ram (
  input  logic                           clk_i,
  input  dnsle_pkg::ram_wr_t             wr_i,
  input  logic [dnsle_pkg::RAM_AW-1:0]   rd_addr_i,
  output logic [dnsle_pkg::BYTE_W-1:0]   rd_data_o
);
  import dnsle_pkg::*;

  logic [BYTE_W-1:0] mem [RAM_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dnsle_cmd_fifo.sv =====
// Two-entry queue of label flush commands between front and back.
// Depends on dnsle_pkg.
module dnsle_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dnsle_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output dnsle_pkg::cmd_t data_o,
  output logic            empty_o
);
  import dnsle_pkg::*;

  cmd_t       entry_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = entry_q[rp_q];

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/dnsle_front.sv =====
// Front end: accepts characters, fills the open label bank, issues flushes.
// Depends on dnsle_pkg.
module dnsle_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [dnsle_pkg::BYTE_W-1:0]  char_in_i,
  input  logic                          end_of_name_i,
  output logic                          full_o,
  input  dnsle_pkg::release_t           rel_i,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output dnsle_pkg::cmd_t               cmd_o,
  output dnsle_pkg::ram_wr_t            wr_o
);
  import dnsle_pkg::*;

  logic             bank_q, bank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [1:0]       busy_q, busy_d;
  logic             accept, is_dot, room, flush;
  logic [CNT_W-1:0] cnt_new;
  logic             ovf_new;

  // Stall while the back end still drains the bank we own, or the command queue is full.
  assign full_o = busy_q[bank_q] | cmd_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    is_dot  = (char_in_i == DOT_CHAR);
    room    = (count_q < CNT_W'(MAX_LABEL));
    flush   = is_dot | end_of_name_i;
    cnt_new = (!is_dot && room) ? count_q + CNT_W'(1) : count_q;
    ovf_new = ovf_q | (~is_dot & ~room);

    wr_o.we   = accept & ~is_dot & room;
    wr_o.addr = {bank_q, count_q};
    wr_o.data = char_in_i;

    cmd_push_o  = accept & flush;
    cmd_o.bank  = bank_q;
    cmd_o.count = cnt_new;
    cmd_o.ovf   = ovf_new;
    cmd_o.term  = end_of_name_i;

    bank_d  = bank_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (flush) begin
        bank_d  = ~bank_q;
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = cnt_new;
        ovf_d   = ovf_new;
      end
    end

    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (cmd_push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      bank_q  <= bank_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// ===== rtl/dnsle_back.sv =====
// Back end: plays out length byte, characters and, at the end of a name, a terminator
// per flush, through a read stage and a small result queue. Depends on dnsle_pkg.
module dnsle_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  dnsle_pkg::cmd_t               cmd_i,
  output logic                          cmd_pop_o,
  output logic [dnsle_pkg::RAM_AW-1:0]  rd_addr_o,
  input  logic [dnsle_pkg::BYTE_W-1:0]  rd_data_i,
  output dnsle_pkg::release_t           rel_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [dnsle_pkg::BYTE_W-1:0]  byte_out_o,
  output logic                          last_of_run_o,
  output logic                          name_done_o,
  output logic                          too_long_o
);
  import dnsle_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_CHR  = 4'b0100,
    ST_TERM = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  cmd_t                cur_q, cur_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                s2_valid_q;
  res_t                s2_q, iss_res;
  logic                s2_mem_q, iss_mem, issue;
  res_t                ofifo_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wp_q, rp_q;
  logic [OFIFO_AW:0]   ocnt_q, ocnt_d;
  logic                credit, at_end, o_pop;
  res_t                push_word, head;

  // Room for one more word counting the one in the read stage.
  assign credit = ((OFIFO_AW+2)'(ocnt_q) + (OFIFO_AW+2)'(s2_valid_q))
                  < (OFIFO_AW+2)'(OFIFO_DEPTH);
  assign at_end    = (idx_q == cur_q.count - CNT_W'(1));
  assign rd_addr_o = {cur_q.bank, idx_q};

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    issue       = 1'b0;
    iss_mem     = 1'b0;
    iss_res     = '0;
    cmd_pop_o   = 1'b0;
    rel_o.valid = 1'b0;
    rel_o.bank  = cur_q.bank;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          state_d   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (credit) begin
          issue        = 1'b1;
          iss_res.data = BYTE_W'(cur_q.count);
          iss_res.last = (cur_q.count == '0) & ~cur_q.term;
          iss_res.tl   = cur_q.ovf;
          idx_d        = '0;
          if (cur_q.count != '0) begin
            state_d = ST_CHR;
          end else if (cur_q.term) begin
            state_d = ST_TERM;
          end else begin
            state_d     = ST_IDLE;
            rel_o.valid = 1'b1;
          end
        end
      end
      ST_CHR: begin
        if (credit) begin
          issue        = 1'b1;
          iss_mem      = 1'b1;
          iss_res.last = at_end & ~cur_q.term;
          iss_res.tl   = cur_q.ovf;
          if (at_end) begin
            if (cur_q.term) begin
              state_d = ST_TERM;
            end else begin
              state_d     = ST_IDLE;
              rel_o.valid = 1'b1;
            end
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      ST_TERM: begin
        if (credit) begin
          issue        = 1'b1;
          iss_res.last = 1'b1;
          iss_res.done = 1'b1;
          state_d      = ST_IDLE;
          rel_o.valid  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Merge the registered store data into the staged word.
  always_comb begin
    push_word = s2_q;
    if (s2_mem_q) begin
      push_word.data = rd_data_i;
    end
  end

  assign empty_o       = (ocnt_q == '0);
  assign o_pop         = pop_i & ~empty_o;
  assign head          = ofifo_q[rp_q];
  assign byte_out_o    = head.data;
  assign last_of_run_o = head.last;
  assign name_done_o   = head.done;
  assign too_long_o    = head.tl;
  assign ocnt_d        = ocnt_q + (OFIFO_AW+1)'(s2_valid_q) - (OFIFO_AW+1)'(o_pop);

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    s2_q     <= iss_res;
    s2_mem_q <= iss_mem;
    if (s2_valid_q) begin
      ofifo_q[wp_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s2_valid_q <= 1'b0;
      wp_q       <= '0;
      rp_q       <= '0;
      ocnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      s2_valid_q <= issue;
      ocnt_q     <= ocnt_d;
      if (s2_valid_q) begin
        wp_q <= wp_q + OFIFO_AW'(1);
      end
      if (o_pop) begin
        rp_q <= rp_q + OFIFO_AW'(1);
      end
    end
  end

endmodule
